### sv/hcce_pkg.sv
// Shared types and constants of the Horn clause core engine.
package hcce_pkg;

  localparam int PROP_W   = 8;
  localparam int WORD_W   = 64;
  localparam int WIDX_W   = 2;
  localparam int MAX_WORDS = 4;

  localparam int DEF_NUM_PROPS   = 256;
  localparam int DEF_NUM_CLAUSES = 1024;
  localparam int DEF_HYP_DEPTH   = 4096;
  localparam int DEF_MAX_HYPS    = 15;

  typedef enum logic [1:0] {
    KIND_HYP   = 2'd0,
    KIND_CONC  = 2'd1,
    KIND_RUN   = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [PROP_W-1:0] prop_index;
  } hcce_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] core_word;
    logic [WIDX_W-1:0] word_index;
    logic              last_word;
    logic              overflow;
  } hcce_out_t;

endpackage

### sv/hcce_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module hcce_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/horn_clause_core_engine.sv
// Horn clause core engine: load sequencer, forward-chaining walker and word emitter.
//
// Usage: items enter on the item channel (item_valid / item_stall), results leave
// on the result channel (result_valid / result_stall); a transfer happens when
// valid is high and stall is low.
// - Hypothesis, clear and most conclusion items are taken and applied in the idle state.
// - A conclusion that stores a clause reads the wait-list head in the idle state,
//   then writes the record and head in S_LINK.
// - A run item walks the clause tables: it pops a proposition and reads its
//   wait-list head, visits each clause on the list, scans its hypotheses, then
//   asserts or relinks it, until it finds the stack empty; all through the one
//   read port of each table memory. It then emits min(ceil(NUM_PROPS/64), 4)
//   truth words, one per cycle while the receiver takes them; last_word marks
//   the final word.
// - The engine takes no item while a clause is stored or a run is walking or emitting. The result
//   register holds a word while result_stall is high and emission waits on it.
// - Reset and a clear item empty the tables at once: wait-list heads carry
//   per-entry valid bits, the other tables are bounded by fill counters, so no
//   clearing pass is needed.
module horn_clause_core_engine
#(
  parameter int NUM_PROPS   = hcce_pkg::DEF_NUM_PROPS,
  parameter int NUM_CLAUSES = hcce_pkg::DEF_NUM_CLAUSES,
  parameter int HYP_DEPTH   = hcce_pkg::DEF_HYP_DEPTH,
  parameter int MAX_HYPS    = hcce_pkg::DEF_MAX_HYPS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  hcce_pkg::hcce_in_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output hcce_pkg::hcce_out_t result
);
  import hcce_pkg::*;

  localparam int TW   = $clog2(NUM_PROPS);
  localparam int SW   = $clog2(NUM_PROPS + 1);
  localparam int CAW  = (NUM_CLAUSES > 1) ? $clog2(NUM_CLAUSES) : 1;
  localparam int CFW  = $clog2(NUM_CLAUSES + 1);
  localparam int HAW  = (HYP_DEPTH > 1) ? $clog2(HYP_DEPTH) : 1;
  localparam int HFW  = $clog2(HYP_DEPTH + 1);
  localparam int PDW  = $clog2(MAX_HYPS + 1);
  localparam int WRAW = (NUM_PROPS + WORD_W - 1) / WORD_W;
  localparam int NWORDS = (WRAW > MAX_WORDS) ? MAX_WORDS : WRAW;
  localparam int PADW = NWORDS * WORD_W;

  typedef struct packed {
    logic [PDW-1:0]    pending;
    logic [HAW-1:0]    base;
    logic              nxt_ok;
    logic [CAW-1:0]    nxt;
    logic [PROP_W-1:0] res;
  } rec_t;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_LINK   = 11'b00000000010,
    S_POP    = 11'b00000000100,
    S_POPW   = 11'b00000001000,
    S_HEADW  = 11'b00000010000,
    S_CHK    = 11'b00000100000,
    S_CLW    = 11'b00001000000,
    S_SCAN   = 11'b00010000000,
    S_HYPW   = 11'b00100000000,
    S_RELINK = 11'b01000000000,
    S_EMIT   = 11'b10000000000
  } state_t;

  state_t            state, state_next;
  logic [NUM_PROPS-1:0] truth, truth_next;
  logic [NUM_PROPS-1:0] head_ok, head_ok_next;
  logic              head_ok_q;
  logic [SW-1:0]     stack_top, stack_top_next;
  logic [HFW-1:0]    hyp_fill, hyp_fill_next;
  logic [CFW-1:0]    clause_fill, clause_fill_next;
  logic [PDW-1:0]    open_cnt, open_cnt_next;
  logic              ovf, ovf_next;
  logic              bad, bad_next;
  logic [PROP_W-1:0] last_hyp, last_hyp_next;
  logic [PROP_W-1:0] prop_q, prop_q_next;
  logic              link_ok, link_ok_next;
  logic [CAW-1:0]    link, link_next;
  logic [CAW-1:0]    c_idx, c_idx_next;
  rec_t              rec, rec_next;
  logic [PDW-1:0]    k, k_next;
  logic [1:0]        word_cnt, word_cnt_next;
  logic              result_valid_next;
  hcce_out_t         result_next;

  logic              hyp_we;
  logic [HAW-1:0]    hyp_waddr, hyp_raddr;
  logic [PROP_W-1:0] hyp_wdata, hyp_rdata;
  logic              stk_we;
  logic [TW-1:0]     stk_waddr, stk_raddr;
  logic [PROP_W-1:0] stk_wdata, stk_rdata;
  logic              head_we;
  logic [TW-1:0]     head_waddr, head_raddr;
  logic [CAW-1:0]    head_wdata, head_rdata;
  logic              rec_we;
  logic [CAW-1:0]    rec_waddr, rec_raddr;
  rec_t              rec_wdata, rec_rdata;

  logic              ap_en;
  logic [TW-1:0]     ap_idx;
  logic              in_range;
  logic [HFW-1:0]    pos;
  logic [PADW-1:0]   tpad;
  logic              out_free;
  logic              emit_last;

  hcce_ram #(.W(PROP_W), .DEPTH(HYP_DEPTH), .AW(HAW)) u_hyp (
    .clk(clk), .we(hyp_we), .waddr(hyp_waddr), .wdata(hyp_wdata),
    .raddr(hyp_raddr), .rdata(hyp_rdata));

  hcce_ram #(.W(PROP_W), .DEPTH(NUM_PROPS), .AW(TW)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata));

  hcce_ram #(.W(CAW), .DEPTH(NUM_PROPS), .AW(TW)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata));

  hcce_ram #(.W($bits(rec_t)), .DEPTH(NUM_CLAUSES), .AW(CAW)) u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(rec_raddr), .rdata(rec_rdata));

  assign item_stall = (state != S_IDLE);
  assign in_range   = 32'(item.prop_index) < NUM_PROPS;
  assign pos        = hyp_fill + HFW'(open_cnt);
  assign tpad       = PADW'(truth);
  assign out_free   = !result_valid || !result_stall;
  assign emit_last  = (word_cnt == 2'(NWORDS - 1));

  always_comb begin
    state_next        = state;
    truth_next        = truth;
    head_ok_next      = head_ok;
    stack_top_next    = stack_top;
    hyp_fill_next     = hyp_fill;
    clause_fill_next  = clause_fill;
    open_cnt_next     = open_cnt;
    ovf_next          = ovf;
    bad_next          = bad;
    last_hyp_next     = last_hyp;
    prop_q_next       = prop_q;
    link_ok_next      = link_ok;
    link_next         = link;
    c_idx_next        = c_idx;
    rec_next          = rec;
    k_next            = k;
    word_cnt_next     = word_cnt;
    result_valid_next = result_valid && result_stall;
    result_next       = result;
    hyp_we     = 1'b0;
    hyp_waddr  = HAW'(pos);
    hyp_wdata  = item.prop_index;
    hyp_raddr  = rec.base + HAW'(k) - HAW'(1);
    stk_we     = 1'b0;
    stk_waddr  = TW'(stack_top);
    stk_wdata  = PROP_W'(ap_idx);
    stk_raddr  = TW'(stack_top - SW'(1));
    head_we    = 1'b0;
    head_waddr = TW'(prop_q);
    head_wdata = c_idx;
    head_raddr = TW'(last_hyp);
    rec_we     = 1'b0;
    rec_waddr  = c_idx;
    rec_wdata  = rec;
    rec_raddr  = link;
    ap_en      = 1'b0;
    ap_idx     = TW'(item.prop_index);

    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          unique case (item.kind)
            KIND_HYP: begin
              if (!bad) begin
                if (!in_range || 32'(open_cnt) >= MAX_HYPS || 32'(pos) >= HYP_DEPTH) begin
                  ovf_next = 1'b1;
                  bad_next = 1'b1;
                end else begin
                  hyp_we        = 1'b1;
                  open_cnt_next = open_cnt + PDW'(1);
                  last_hyp_next = item.prop_index;
                end
              end
            end
            KIND_CONC: begin
              priority if (bad || !in_range) begin
                ovf_next      = 1'b1;
                open_cnt_next = '0;
                bad_next      = 1'b0;
              end else if (open_cnt == '0) begin
                ap_en = 1'b1;
              end else if (32'(clause_fill) >= NUM_CLAUSES) begin
                ovf_next      = 1'b1;
                open_cnt_next = '0;
              end else begin
                prop_q_next = item.prop_index;
                state_next  = S_LINK;
              end
            end
            KIND_RUN: begin
              state_next = S_POP;
            end
            KIND_CLEAR: begin
              truth_next       = '0;
              head_ok_next     = '0;
              stack_top_next   = '0;
              hyp_fill_next    = '0;
              clause_fill_next = '0;
              open_cnt_next    = '0;
              ovf_next         = 1'b0;
              bad_next         = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_LINK: begin
        // new clause goes to the head of its last hypothesis' wait list
        rec_we            = 1'b1;
        rec_waddr         = CAW'(clause_fill);
        rec_wdata.pending = open_cnt;
        rec_wdata.base    = HAW'(hyp_fill);
        rec_wdata.nxt_ok  = head_ok_q;
        rec_wdata.nxt     = head_rdata;
        rec_wdata.res     = prop_q;
        head_we           = 1'b1;
        head_waddr        = TW'(last_hyp);
        head_wdata        = CAW'(clause_fill);
        head_ok_next[TW'(last_hyp)] = 1'b1;
        clause_fill_next  = clause_fill + CFW'(1);
        hyp_fill_next     = hyp_fill + HFW'(open_cnt);
        open_cnt_next     = '0;
        state_next        = S_IDLE;
      end
      S_POP: begin
        if (stack_top == '0) begin
          word_cnt_next = '0;
          state_next    = S_EMIT;
        end else begin
          stack_top_next = stack_top - SW'(1);
          state_next     = S_POPW;
        end
      end
      S_POPW: begin
        head_raddr = TW'(stk_rdata);
        state_next = S_HEADW;
      end
      S_HEADW: begin
        link_ok_next = head_ok_q;
        link_next    = head_rdata;
        state_next   = S_CHK;
      end
      S_CHK: begin
        if (!link_ok) begin
          state_next = S_POP;
        end else begin
          c_idx_next = link;
          state_next = S_CLW;
        end
      end
      S_CLW: begin
        rec_next     = rec_rdata;
        link_ok_next = rec_rdata.nxt_ok;
        link_next    = rec_rdata.nxt;
        k_next       = (rec_rdata.pending != '0) ? rec_rdata.pending - PDW'(1) : '0;
        state_next   = S_SCAN;
      end
      S_SCAN: begin
        if (k == '0) begin
          ap_en      = 1'b1;
          ap_idx     = TW'(rec.res);
          state_next = S_CHK;
        end else begin
          state_next = S_HYPW;
        end
      end
      S_HYPW: begin
        if (!truth[TW'(hyp_rdata)]) begin
          head_raddr  = TW'(hyp_rdata);
          prop_q_next = hyp_rdata;
          state_next  = S_RELINK;
        end else begin
          k_next     = k - PDW'(1);
          state_next = S_SCAN;
        end
      end
      S_RELINK: begin
        rec_we            = 1'b1;
        rec_wdata.pending = k;
        rec_wdata.nxt_ok  = head_ok_q;
        rec_wdata.nxt     = head_rdata;
        head_we           = 1'b1;
        head_ok_next[TW'(prop_q)] = 1'b1;
        state_next        = S_CHK;
      end
      S_EMIT: begin
        if (out_free) begin
          result_valid_next      = 1'b1;
          result_next.core_word  = tpad[word_cnt * WORD_W +: WORD_W];
          result_next.word_index = word_cnt;
          result_next.last_word  = emit_last;
          result_next.overflow   = ovf;
          if (emit_last) begin
            state_next = S_IDLE;
          end else begin
            word_cnt_next = word_cnt + 2'd1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase

    // make a proposition true and push it once
    if (ap_en && !truth[ap_idx]) begin
      truth_next[ap_idx] = 1'b1;
      if (32'(stack_top) < NUM_PROPS) begin
        stk_we         = 1'b1;
        stk_wdata      = PROP_W'(ap_idx);
        stack_top_next = stack_top + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      truth        <= '0;
      head_ok      <= '0;
      stack_top    <= '0;
      hyp_fill     <= '0;
      clause_fill  <= '0;
      open_cnt     <= '0;
      ovf          <= 1'b0;
      bad          <= 1'b0;
      word_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      truth        <= truth_next;
      head_ok      <= head_ok_next;
      stack_top    <= stack_top_next;
      hyp_fill     <= hyp_fill_next;
      clause_fill  <= clause_fill_next;
      open_cnt     <= open_cnt_next;
      ovf          <= ovf_next;
      bad          <= bad_next;
      word_cnt     <= word_cnt_next;
      result_valid <= result_valid_next;
    end
    head_ok_q <= head_ok[head_raddr];
    last_hyp  <= last_hyp_next;
    prop_q    <= prop_q_next;
    link_ok   <= link_ok_next;
    link      <= link_next;
    c_idx     <= c_idx_next;
    rec       <= rec_next;
    k         <= k_next;
    result    <= result_next;
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    32'(stack_top) <= NUM_PROPS)
    else $error("true stack over depth");

  a_open_bound: assert property (@(posedge clk) disable iff (rst)
    32'(open_cnt) <= MAX_HYPS)
    else $error("open clause over hypothesis limit");

  a_link_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINK) |-> (32'(clause_fill) < NUM_CLAUSES))
    else $error("clause stored with table full");

  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_EMIT))
    else $error("result loaded outside emit");

endmodule

### verif/horn_clause_core_engine_test.sv
// Self-checking testbench of the Horn clause core engine: directed table plus random clause sets.
`timescale 1ns / 100ps

module horn_clause_core_engine_test;
  import hcce_pkg::*;

  localparam int NPROPS = DEF_NUM_PROPS;
  localparam int NCLAUSES = DEF_NUM_CLAUSES;
  localparam int HDEPTH = DEF_HYP_DEPTH;
  localparam int MHYPS = DEF_MAX_HYPS;
  localparam int NWORDS = ((NPROPS + 63) / 64) > MAX_WORDS ? MAX_WORDS : (NPROPS + 63) / 64;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  hcce_in_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  hcce_out_t result;

  horn_clause_core_engine uut (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // engine model state
  bit          truth[NPROPS];
  int unsigned wait_hd[NPROPS];
  int unsigned cl_pending[NCLAUSES];
  int unsigned cl_base[NCLAUSES];
  int unsigned cl_next[NCLAUSES];
  int unsigned cl_result[NCLAUSES];
  int unsigned hyps[HDEPTH];
  int unsigned pstack[NPROPS];
  int unsigned sp, hfill, cfill, open_cnt;
  bit          ovf, open_bad;

  hcce_out_t core_words_q[$];
  int errors = 0;
  int cycles = 0;
  bit long_hold = 1'b0;

  task automatic clear_model();
    for (int i = 0; i < NPROPS; i++) begin
      truth[i] = 0;
      wait_hd[i] = 0;
    end
    sp = 0; hfill = 0; cfill = 0; open_cnt = 0; ovf = 0; open_bad = 0;
  endtask

  function automatic void make_true(int unsigned p);
    if (p >= NPROPS || truth[p]) return;
    truth[p] = 1;
    if (sp < NPROPS) begin
      pstack[sp] = p;
      sp++;
    end
  endfunction

  task automatic chain_forward();
    int unsigned p, link, c, nxt, k, q;
    bit moved;
    while (sp > 0) begin
      sp--;
      p = pstack[sp];
      link = wait_hd[p];
      while (link != 0 && link <= NCLAUSES) begin
        c = link - 1;
        nxt = cl_next[c];
        k = cl_pending[c] > 0 ? cl_pending[c] - 1 : 0;
        moved = 0;
        while (k > 0 && !moved) begin
          q = hyps[cl_base[c] + k - 1];
          if (q < NPROPS && !truth[q]) begin
            cl_pending[c] = k;
            cl_next[c] = wait_hd[q];
            wait_hd[q] = c + 1;
            moved = 1;
          end else begin
            k--;
          end
        end
        if (!moved) make_true(cl_result[c]);
        link = nxt;
      end
    end
  endtask

  // Applies one accepted item to the model and queues the words it produces.
  task automatic predict_core(input hcce_in_t it);
    int unsigned p, c, last;
    hcce_out_t w;
    p = it.prop_index;
    case (it.kind)
      KIND_HYP: begin
        if (!open_bad) begin
          if (p >= NPROPS || open_cnt >= MHYPS || hfill + open_cnt >= HDEPTH) begin
            ovf = 1;
            open_bad = 1;
          end else begin
            hyps[hfill + open_cnt] = p;
            open_cnt++;
          end
        end
      end
      KIND_CONC: begin
        if (open_bad || p >= NPROPS) begin
          ovf = 1; open_cnt = 0; open_bad = 0;
        end else if (open_cnt == 0) begin
          make_true(p);
        end else if (cfill >= NCLAUSES) begin
          ovf = 1; open_cnt = 0; open_bad = 0;
        end else begin
          c = cfill++;
          cl_pending[c] = open_cnt;
          cl_base[c] = hfill;
          cl_result[c] = p;
          last = hyps[hfill + open_cnt - 1];
          cl_next[c] = wait_hd[last];
          wait_hd[last] = c + 1;
          hfill += open_cnt;
          open_cnt = 0;
        end
      end
      KIND_CLEAR: clear_model();
      default: begin
        chain_forward();
        for (int i = 0; i < NWORDS; i++) begin
          for (int b = 0; b < 64; b++) w.core_word[b] = truth[i * 64 + b];
          w.word_index = i[WIDX_W-1:0];
          w.last_word = (i == NWORDS - 1);
          w.overflow = ovf;
          core_words_q = {core_words_q, w};
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // directed table
  typedef struct {
    kind_t        kind;
    int unsigned  prop;
    bit           typed;
    logic [63:0]  word0;
    bit           ovf_exp;
  } row_t;

  row_t dir_rows[$];

  task automatic add_row(input kind_t k, input int unsigned p, input bit t = 0,
                         input logic [63:0] w0 = '0, input bit o = 0);
    row_t r;
    r.kind = k; r.prop = p; r.typed = t; r.word0 = w0; r.ovf_exp = o;
    dir_rows = {dir_rows, r};
  endtask

  hcce_in_t send_q[$];
  hcce_out_t typed_q[$];
  bit typed_flag_q[$];
  bit sender_done = 1'b0;

  // sender
  initial begin
    int gap;
    int sent;
    bit drained;
    hcce_in_t cur;
    sent = 0;
    drained = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (send_q.size() > 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      cur = send_q.pop_front();
      item_valid <= 1'b1;
      item <= cur;
      @(posedge clk);
      while (item_stall) @(posedge clk);
      sent++;
      // hold off once until every expected word has come back
      if (!drained && sent >= 100 && cur.kind == KIND_RUN) begin
        drained = 1'b1;
        item_valid <= 1'b0;
        @(posedge clk);
        while (core_words_q.size() > 0) @(posedge clk);
      end
    end
    item_valid <= 1'b0;
    sender_done = 1'b1;
  end

  // accepted-item monitor
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) predict_core(item);
  end

  // receiver stall pattern
  initial begin
    int hold;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        result_stall <= 1'b1;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      hold = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) hold = 0;
      if (hold != 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    hcce_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (core_words_q.size() == 0) begin
        report_mismatch("unexpected transfer", result.core_word, '0);
      end else begin
        want = core_words_q.pop_front();
        if (result.core_word !== want.core_word)
          report_mismatch("core_word", result.core_word, want.core_word);
        if (result.word_index !== want.word_index)
          report_mismatch("word_index", result.word_index, want.word_index);
        if (result.last_word !== want.last_word)
          report_mismatch("last_word", result.last_word, want.last_word);
        if (result.overflow !== want.overflow)
          report_mismatch("overflow", result.overflow, want.overflow);
        if (typed_flag_q.size() > 0 && want.word_index == 0) begin
          if (typed_flag_q.pop_front()) begin
            if (result.core_word !== typed_q[0].core_word)
              report_mismatch("table word0", result.core_word, typed_q[0].core_word);
            if (result.overflow !== typed_q[0].overflow)
              report_mismatch("table overflow", result.overflow, typed_q[0].overflow);
          end
          if (typed_q.size() > 0) void'(typed_q.pop_front());
        end
      end
    end
  end

  task automatic push_item(input kind_t k, input int unsigned p);
    hcce_in_t it;
    it.kind = k;
    it.prop_index = p[7:0];
    send_q = {send_q, it};
  endtask

  // random clause set: chains so the walk goes deep, some noise
  task automatic push_random_set(input int n_clauses);
    int nh;
    for (int c = 0; c < n_clauses; c++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_item(kind_t'($urandom_range(0, 3)), $urandom_range(0, 255));
      end else begin
        nh = $urandom_range(0, 9) == 0 ? $urandom_range(14, 17) : $urandom_range(0, 3);
        for (int h = 0; h < nh; h++) push_item(KIND_HYP, $urandom_range(0, 31));
        push_item(KIND_CONC, $urandom_range(0, 9) == 0 ? $urandom_range(0, 255)
                                                       : $urandom_range(0, 31));
      end
    end
    push_item(KIND_RUN, 0);
  endtask

  initial begin
    hcce_out_t tw;
    clear_model();
    // after reset: empty core
    add_row(KIND_RUN, 0, 1, 64'h0, 0);
    // fact 0 and fact 255
    add_row(KIND_CONC, 0);
    add_row(KIND_CONC, 255);
    add_row(KIND_RUN, 0, 1, 64'h1, 0);
    // 0 -> 1, 1 & 0 -> 2, both wait on 0, which has already been walked
    add_row(KIND_HYP, 0);
    add_row(KIND_CONC, 1);
    add_row(KIND_HYP, 1);
    add_row(KIND_HYP, 0);
    add_row(KIND_CONC, 2);
    add_row(KIND_RUN, 0, 1, 64'h1, 0);
    // clause waiting on a hypothesis that is not true: its conclusion stays false
    add_row(KIND_HYP, 2);
    add_row(KIND_CONC, 3);
    add_row(KIND_RUN, 0, 1, 64'h1, 0);
    // open clause across a run
    add_row(KIND_HYP, 5);
    add_row(KIND_RUN, 0, 1, 64'h1, 0);
    add_row(KIND_CONC, 6);
    add_row(KIND_CONC, 5);
    add_row(KIND_RUN, 0, 1, 64'h61, 0);
    // too many hypotheses: bad clause, overflow set
    for (int i = 0; i < 16; i++) add_row(KIND_HYP, i + 100);
    add_row(KIND_CONC, 9);
    add_row(KIND_RUN, 0, 1, 64'h61, 1);
    add_row(KIND_CLEAR, 170);
    add_row(KIND_RUN, 0, 1, 64'h0, 0);
    foreach (dir_rows[i]) begin
      push_item(dir_rows[i].kind, dir_rows[i].prop);
      if (dir_rows[i].kind == KIND_RUN) begin
        typed_flag_q = {typed_flag_q, dir_rows[i].typed};
        tw = '0;
        tw.core_word = dir_rows[i].word0;
        tw.overflow = dir_rows[i].ovf_exp;
        typed_q = {typed_q, tw};
      end
    end
    // random part
    for (int s = 0; s < 11; s++) begin
      push_random_set($urandom_range(2, 8));
      if ($urandom_range(0, 4) == 0) push_item(KIND_CLEAR, $urandom_range(0, 255));
    end
  end

  // pressure: long receiver hold mid-run, and a sender pause until drained
  initial begin
    @(negedge rst);
    repeat (200) @(posedge clk);
    long_hold = 1'b1;
  end

  // end of run
  initial begin
    @(negedge rst);
    while (!sender_done || core_words_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TIMEOUT at cycle %0d", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
